// ----- rtl/core/dhtrx_pkg.sv -----
`default_nettype none
package dhtrx_pkg;

  localparam int unsigned StartLowW = 16;
  localparam int unsigned LimitW    = 8;
  localparam int unsigned CountW    = 16;
  localparam int unsigned BitIdxW   = 5;
  localparam int unsigned WordW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned DataW     = 32;

  localparam logic [StartLowW-1:0] START_LOW_RST = 16'd20000;
  localparam logic [LimitW-1:0]    WAIT_LIMIT_RST = 8'd100;
  localparam logic [LimitW-1:0]    ONE_THRESH_RST = 8'd40;

  // Register index, taken from paddr[3:2].
  localparam logic [1:0] REG_START_LOW  = 2'd0;
  localparam logic [1:0] REG_WAIT_LIMIT = 2'd1;
  localparam logic [1:0] REG_ONE_THRESH = 2'd2;

  // Error flag bit positions.
  localparam int unsigned ERR_HS  = 0;
  localparam int unsigned ERR_HUM = 1;
  localparam int unsigned ERR_TMP = 2;

  typedef struct packed {
    logic [StartLowW-1:0] start_low_ticks;
    logic [LimitW-1:0]    wait_limit;
    logic [LimitW-1:0]    one_threshold;
  } dhtrx_cfg_t;

  typedef struct packed {
    logic              drive_low;
    logic              done_res;
    logic [ByteW-1:0]  humidity;
    logic [ByteW-1:0]  temperature;
    logic              handshake_error;
    logic              humidity_error;
    logic              temperature_error;
    logic              busy_res;
  } dhtrx_res_t;

endpackage
`default_nettype wire

// ----- rtl/core/dhtrx_core.sv -----
`default_nettype none
module dhtrx_core
  import dhtrx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic       line_level,
  input  wire logic       start_req,
  input  wire dhtrx_cfg_t cfg,
  output dhtrx_res_t      res
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_HS1   = 3'd2,
    PH_HS2   = 3'd3,
    PH_HS3   = 3'd4,
    PH_SYNC  = 3'd5,
    PH_DATA  = 3'd6
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [CountW-1:0]    cnt_r, cnt_nxt;
  logic [BitIdxW-1:0]   bidx_r, bidx_nxt;
  logic [WordW-1:0]     shift_r, shift_nxt;
  logic [ByteW-1:0]     hum_hold_r, hum_hold_nxt;
  logic [2:0]           err_r, err_nxt;

  logic [CountW-1:0]    cnt_inc;
  logic [CountW-1:0]    cnt_eff;
  logic [CountW-1:0]    limit_ext;
  logic [CountW-1:0]    start_ext;
  logic                 wait_lvl;
  logic                 leave;
  logic                 timed_out;
  logic [CountW-1:0]    next_cnt;
  logic [2:0]           word_err;
  logic [2:0]           err_acc;
  logic                 data_bit;
  logic [WordW-1:0]     shift_new;
  logic [ByteW-1:0]     upper;

  assign cnt_inc   = (cnt_r == {CountW{1'b1}}) ? cnt_r : cnt_r + 1'b1;
  assign limit_ext = {{(CountW-LimitW){1'b0}}, cfg.wait_limit};
  assign start_ext = cfg.start_low_ticks;
  assign wait_lvl  = !(phase_r == PH_HS2 || phase_r == PH_SYNC);
  assign leave     = (line_level != wait_lvl) || (cnt_inc >= limit_ext);
  assign timed_out = (line_level == wait_lvl) && (cnt_inc >= limit_ext);
  assign next_cnt  = (line_level == wait_lvl) ? '0 : CountW'(1);
  // The bit decision sees the count after this tick's increment on a timeout.
  assign cnt_eff   = timed_out ? cnt_inc : cnt_r;
  assign word_err  = bidx_r[BitIdxW-1] ? 3'(1 << ERR_TMP) : 3'(1 << ERR_HUM);
  assign data_bit  = cnt_eff > {{(CountW-LimitW){1'b0}}, cfg.one_threshold};
  assign shift_new = {shift_r[WordW-2:0], data_bit};
  assign upper     = shift_new[WordW-1 -: ByteW];

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    bidx_nxt     = bidx_r;
    shift_nxt    = shift_r;
    hum_hold_nxt = hum_hold_r;
    err_nxt      = err_r;
    err_acc      = err_r;
    res          = '0;
    unique case (phase_r)
      PH_IDLE: begin
        if (start_req) begin
          err_nxt      = '0;
          hum_hold_nxt = '0;
          shift_nxt    = '0;
          bidx_nxt     = '0;
          res.drive_low = 1'b1;
          // The request tick is already the first low tick of the pulse.
          if (start_ext <= CountW'(1)) begin
            phase_nxt = PH_HS1;
            cnt_nxt   = '0;
          end else begin
            phase_nxt = PH_START;
            cnt_nxt   = CountW'(1);
          end
        end
      end
      PH_START: begin
        res.drive_low = 1'b1;
        if (cnt_inc >= start_ext) begin
          phase_nxt = PH_HS1;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      PH_HS1, PH_HS2, PH_HS3, PH_SYNC, PH_DATA: begin
        if (!leave) begin
          cnt_nxt = cnt_inc;
        end else begin
          cnt_nxt = next_cnt;
          unique case (phase_r)
            PH_HS1: begin
              err_nxt   = err_r | (timed_out ? 3'(1 << ERR_HS) : 3'b0);
              phase_nxt = PH_HS2;
            end
            PH_HS2: begin
              err_nxt   = err_r | (timed_out ? 3'(1 << ERR_HS) : 3'b0);
              phase_nxt = PH_HS3;
            end
            PH_HS3: begin
              err_acc = err_r | (timed_out ? 3'(1 << ERR_HS) : 3'b0);
              err_nxt = err_acc;
              if (err_acc[ERR_HS]) begin
                res.done_res          = 1'b1;
                res.handshake_error   = err_acc[ERR_HS];
                res.humidity_error    = err_acc[ERR_HUM];
                res.temperature_error = err_acc[ERR_TMP];
                phase_nxt = PH_IDLE;
                cnt_nxt   = '0;
              end else begin
                phase_nxt = PH_SYNC;
                bidx_nxt  = '0;
                shift_nxt = '0;
              end
            end
            PH_SYNC: begin
              err_nxt   = err_r | (timed_out ? word_err : 3'b0);
              phase_nxt = PH_DATA;
            end
            default: begin
              err_acc   = err_r | (timed_out ? word_err : 3'b0);
              err_nxt   = err_acc;
              shift_nxt = shift_new;
              phase_nxt = PH_SYNC;
              bidx_nxt  = bidx_r + 1'b1;
              if (bidx_r[BitIdxW-2:0] == {(BitIdxW-1){1'b1}}) begin
                if (bidx_r[BitIdxW-1]) begin
                  res.done_res          = 1'b1;
                  res.humidity          = hum_hold_r;
                  res.temperature       = err_acc[ERR_TMP] ? '0 : upper;
                  res.handshake_error   = err_acc[ERR_HS];
                  res.humidity_error    = err_acc[ERR_HUM];
                  res.temperature_error = err_acc[ERR_TMP];
                  phase_nxt = PH_IDLE;
                  cnt_nxt   = '0;
                end else begin
                  hum_hold_nxt = err_acc[ERR_HUM] ? '0 : upper;
                end
              end
            end
          endcase
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        cnt_nxt   = '0;
      end
    endcase
    res.busy_res = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      cnt_r      <= '0;
      bidx_r     <= '0;
      shift_r    <= '0;
      hum_hold_r <= '0;
      err_r      <= '0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      bidx_r     <= bidx_nxt;
      shift_r    <= shift_nxt;
      hum_hold_r <= hum_hold_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/single_wire_humidity_sensor_receiver.sv -----
// Receiver for a single-wire humidity and temperature sensor.
// Each input word is one microsecond tick: the sampled data line level and a
// start request. Each accepted word yields exactly one result word that
// tells whether to pull the line low on this tick, and on the tick a reading
// ends, the humidity, the signed temperature and three timeout flags.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. A result is registered in the result register, or in the skid
// register while that one is held; the block takes one input word every
// cycle while in_stall is low; each tick step is one pass through the decode
// logic between the sequencer state registers and the result register.
// A two-entry output buffer (result register plus skid register) lets the
// input keep flowing while one result waits; in_stall rises only when both
// entries are full, and falls as soon as the receiver takes a word.
// Reset (synchronous, rst_n low) returns the sequencer to idle, empties the
// output buffer and loads the registers with their defaults: start pulse
// 20000 ticks, level wait limit 100 ticks, one-bit threshold 40 ticks.
// The user must write the registers through the APB port only while no reading is busy; the block does not check.
`default_nettype none
module single_wire_humidity_sensor_receiver
  import dhtrx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_line_level,
  input  wire logic              in_start_req,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_drive_low,
  output logic                   out_done_res,
  output logic [ByteW-1:0]       out_humidity,
  output logic signed [ByteW-1:0] out_temperature,
  output logic                   out_handshake_error,
  output logic                   out_humidity_error,
  output logic                   out_temperature_error,
  output logic                   out_busy_res,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]       prdata,
  output logic                   pready
);

  dhtrx_cfg_t cfg_r;
  dhtrx_res_t step_res;
  dhtrx_res_t out_r;
  dhtrx_res_t skid_r;
  logic       out_valid_r;
  logic       skid_valid_r;
  logic       in_accept;
  logic       out_take;
  logic       cfg_wr;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_low_ticks <= START_LOW_RST;
      cfg_r.wait_limit      <= WAIT_LIMIT_RST;
      cfg_r.one_threshold   <= ONE_THRESH_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_START_LOW:  cfg_r.start_low_ticks <= pwdata[StartLowW-1:0];
        REG_WAIT_LIMIT: cfg_r.wait_limit      <= pwdata[LimitW-1:0];
        REG_ONE_THRESH: cfg_r.one_threshold   <= pwdata[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_START_LOW:  prdata = {{(DataW-StartLowW){1'b0}}, cfg_r.start_low_ticks};
      REG_WAIT_LIMIT: prdata = {{(DataW-LimitW){1'b0}}, cfg_r.wait_limit};
      REG_ONE_THRESH: prdata = {{(DataW-LimitW){1'b0}}, cfg_r.one_threshold};
      default:        prdata = '0;
    endcase
  end

  // The sequencer advances by one tick on every accepted input word.
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;

  dhtrx_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (in_accept),
    .line_level (in_line_level),
    .start_req  (in_start_req),
    .cfg        (cfg_r),
    .res        (step_res)
  );

  // Output buffer: the skid entry only fills when the result register is
  // held by a stalled receiver, and it drains into the result register first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_accept) begin
      if (out_valid_r && !out_take) begin
        skid_valid_r <= 1'b1;
      end
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (in_accept) begin
      if (out_valid_r && !out_take) begin
        skid_r <= step_res;
      end else begin
        out_r <= step_res;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_drive_low         = out_r.drive_low;
  assign out_done_res          = out_r.done_res;
  assign out_humidity          = out_r.humidity;
  assign out_temperature       = signed'(out_r.temperature);
  assign out_handshake_error   = out_r.handshake_error;
  assign out_humidity_error    = out_r.humidity_error;
  assign out_temperature_error = out_r.temperature_error;
  assign out_busy_res          = out_r.busy_res;

endmodule
`default_nettype wire

// ----- dv/tb_single_wire_humidity_sensor_receiver.sv -----
module tb_single_wire_humidity_sensor_receiver;
  timeunit 1ns;
  timeprecision 1ps;
  import dhtrx_pkg::*;

  // The watchdog limit is set well above the slowest legal run. That run
  // covers a few hundred ticks of short readings, the register accesses,
  // and input gaps and output stalls on every word.
  localparam int CycleLimit = 100_000;
  // This register slot decodes to no register, so a write there must change
  // nothing.
  localparam logic [1:0] RegSpare = 2'd3;

  // Phases of the sequencer in the predictor.
  typedef enum logic [3:0] {
    SeqIdle, SeqPulse, SeqRespHigh, SeqRespLow, SeqRespRelease, SeqBitSync, SeqBitHigh
  } seq_phase_t;

  // Ways in which a generated sensor reply departs from a clean frame.
  typedef enum {
    FaultNone, FaultResponse, FaultHumidity, FaultTemperature, FaultAny
  } fault_t;

  // One tick as the sensor side presents it.
  typedef struct packed {
    logic line;
    logic start;
  } tick_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic in_line_level = 1'b0;
  logic in_start_req = 1'b0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic out_drive_low;
  logic out_done_res;
  logic [ByteW-1:0] out_humidity;
  logic signed [ByteW-1:0] out_temperature;
  logic out_handshake_error;
  logic out_humidity_error;
  logic out_temperature_error;
  logic out_busy_res;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  // Ticks waiting to be sent, and the results that the sequencer must
  // produce, oldest first.
  tick_t tick_q[$];
  dhtrx_res_t reading_q[$];

  // Sequencer state and register copies in the predictor.
  seq_phase_t seq_ph = SeqIdle;
  logic [CountW-1:0] tick_cnt = '0;
  logic [BitIdxW-1:0] bit_idx = '0;
  logic [WordW-1:0] shift_reg = '0;
  logic [ByteW-1:0] hum_hold = '0;
  logic [2:0] err_bits = '0;
  logic [StartLowW-1:0] cfg_start_low = START_LOW_RST;
  logic [LimitW-1:0] cfg_wait_limit = WAIT_LIMIT_RST;
  logic [LimitW-1:0] cfg_one_thresh = ONE_THRESH_RST;

  int err_cnt = 0;
  int result_cnt = 0;
  int cycle_cnt = 0;
  bit word_taken = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;

  always #5 clk = ~clk;

  single_wire_humidity_sensor_receiver dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_line_level         (in_line_level),
    .in_start_req          (in_start_req),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_drive_low         (out_drive_low),
    .out_done_res          (out_done_res),
    .out_humidity          (out_humidity),
    .out_temperature       (out_temperature),
    .out_handshake_error   (out_handshake_error),
    .out_humidity_error    (out_humidity_error),
    .out_temperature_error (out_temperature_error),
    .out_busy_res          (out_busy_res),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  // Advance the sequencer by one tick and return the result word for it.
  // A level wait ends either when the line leaves the waited level or when
  // its count reaches the wait limit. A timeout sets the error flag of the
  // word that is being received. A level change counts as the first tick of
  // the next wait, and a timeout makes the next wait start from zero.
  function automatic dhtrx_res_t sensor_step(logic line, logic start);
    dhtrx_res_t r;
    logic leave;
    logic timed_out;
    logic one_bit;
    logic waited;
    logic [CountW-1:0] next_cnt;
    logic [2:0] word_err;
    r = '0;
    leave = 1'b0;
    timed_out = 1'b0;
    next_cnt = '0;
    case (seq_ph)
      SeqIdle: begin
        if (start) begin
          err_bits = '0;
          hum_hold = '0;
          shift_reg = '0;
          bit_idx = '0;
          r.drive_low = 1'b1;
          // The start tick is itself the first low tick of the pulse.
          if (cfg_start_low <= 1) begin
            seq_ph = SeqRespHigh;
            tick_cnt = '0;
          end else begin
            seq_ph = SeqPulse;
            tick_cnt = CountW'(1);
          end
        end
      end
      SeqPulse: begin
        r.drive_low = 1'b1;
        if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= cfg_start_low) begin
          seq_ph = SeqRespHigh;
          tick_cnt = '0;
        end
      end
      default: begin
        waited = (seq_ph == SeqRespLow || seq_ph == SeqBitSync) ? 1'b0 : 1'b1;
        if (line == waited) begin
          if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
          if (tick_cnt >= cfg_wait_limit) begin
            leave = 1'b1;
            timed_out = 1'b1;
          end
        end else begin
          leave = 1'b1;
          next_cnt = CountW'(1);
        end
        if (leave) begin
          word_err = bit_idx[4] ? 3'(1 << ERR_TMP) : 3'(1 << ERR_HUM);
          case (seq_ph)
            SeqRespHigh, SeqRespLow: begin
              if (timed_out) err_bits[ERR_HS] = 1'b1;
              seq_ph = (seq_ph == SeqRespHigh) ? SeqRespLow : SeqRespRelease;
            end
            SeqRespRelease: begin
              if (timed_out) err_bits[ERR_HS] = 1'b1;
              if (err_bits[ERR_HS]) begin
                // A failed response ends the reading with both values zero.
                r.done_res = 1'b1;
                r.handshake_error = err_bits[ERR_HS];
                r.humidity_error = err_bits[ERR_HUM];
                r.temperature_error = err_bits[ERR_TMP];
                seq_ph = SeqIdle;
              end else begin
                seq_ph = SeqBitSync;
                bit_idx = '0;
                shift_reg = '0;
              end
            end
            SeqBitSync: begin
              if (timed_out) err_bits = err_bits | word_err;
              seq_ph = SeqBitHigh;
            end
            default: begin
              one_bit = (tick_cnt > cfg_one_thresh);
              if (timed_out) err_bits = err_bits | word_err;
              shift_reg = {shift_reg[WordW-2:0], one_bit};
              seq_ph = SeqBitSync;
              if (bit_idx[3:0] == 4'hF) begin
                if (bit_idx[4]) begin
                  r.done_res = 1'b1;
                  r.humidity = hum_hold;
                  r.temperature = err_bits[ERR_TMP] ? '0 : shift_reg[WordW-1:ByteW];
                  r.handshake_error = err_bits[ERR_HS];
                  r.humidity_error = err_bits[ERR_HUM];
                  r.temperature_error = err_bits[ERR_TMP];
                  seq_ph = SeqIdle;
                end else begin
                  hum_hold = err_bits[ERR_HUM] ? '0 : shift_reg[WordW-1:ByteW];
                end
              end
              bit_idx = bit_idx + 1'b1;
            end
          endcase
          tick_cnt = (seq_ph == SeqIdle) ? '0 : next_cnt;
        end
      end
    endcase
    r.busy_res = (seq_ph != SeqIdle);
    return r;
  endfunction

  function automatic string res_text(dhtrx_res_t r);
    return $sformatf("drive=%b done=%b hum=%0d temp=%0d err=%b%b%b busy=%b",
                     r.drive_low, r.done_res, r.humidity, $signed(r.temperature),
                     r.handshake_error, r.humidity_error, r.temperature_error,
                     r.busy_res);
  endfunction

  // Only the first ten mismatches are printed. Later ones are only counted.
  task automatic report(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR: %s", msg);
  endtask

  // On each rising edge, an accepted input word is run through the
  // predictor first, and then an accepted result word is checked against
  // the oldest prediction. The order does not matter for a block with a
  // registered output, but it would still hold for a combinational one.
  always @(posedge clk) begin : check_results
    dhtrx_res_t want;
    dhtrx_res_t seen;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = sensor_step(in_line_level, in_start_req);
        reading_q.push_back(want);
        word_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        seen.drive_low = out_drive_low;
        seen.done_res = out_done_res;
        seen.humidity = out_humidity;
        seen.temperature = out_temperature;
        seen.handshake_error = out_handshake_error;
        seen.humidity_error = out_humidity_error;
        seen.temperature_error = out_temperature_error;
        seen.busy_res = out_busy_res;
        if (reading_q.size() == 0) begin
          report($sformatf("result %0d arrived with nothing expected: %s",
                           result_cnt, res_text(seen)));
        end else begin
          want = reading_q.pop_front();
          if (seen !== want)
            report($sformatf("result %0d: expected %s, got %s",
                             result_cnt, res_text(want), res_text(seen)));
        end
        result_cnt++;
      end
    end
  end

  // Tick sender. A word stays on the pins until it is taken. After a word
  // is loaded, a short random gap may follow it. The next value of valid is
  // worked out first, so valid gets a single assignment per edge.
  always @(negedge clk) begin : send_ticks
    tick_t nxt;
    logic vld;
    vld = in_valid;
    if (word_taken) begin
      vld = 1'b0;
      word_taken = 1'b0;
    end
    if (!vld) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (tick_q.size() > 0) begin
        nxt = tick_q.pop_front();
        in_line_level <= nxt.line;
        in_start_req <= nxt.start;
        vld = 1'b1;
        if (send_idle && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 3);
      end
    end
    in_valid <= vld;
  end

  // Result receiver. It stalls in random bursts.
  always @(negedge clk) begin : stall_results
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (recv_idle && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int pick(int lo, int hi);
    return (hi <= lo) ? lo : int'($urandom_range(hi, lo));
  endfunction

  task automatic put_tick(logic line, logic start);
    tick_t t;
    t.line = line;
    t.start = start;
    tick_q.push_back(t);
  endtask

  // A stretch of one line level. Now and then a start request is raised
  // during it, which must be ignored while a reading is busy.
  task automatic put_level(logic lvl, int n);
    repeat (n) put_tick(lvl, $urandom_range(0, 15) == 0);
  endtask

  task automatic put_noise(int n, bit may_start);
    repeat (n) put_tick(1'($urandom_range(0, 1)), may_start && $urandom_range(0, 9) == 0);
  endtask

  // Length of one waited level. Most levels are very short, so that frames
  // stay cheap. Some reach up to just below the limit. An overlong level is
  // at least the wait limit and forces a timeout.
  function automatic int level_len(bit over);
    int lim;
    lim = cfg_wait_limit;
    if (over) return (lim > 0 ? lim : 1) + $urandom_range(0, 2);
    if ($urandom_range(0, 4) != 0) return pick(1, (lim - 1 < 2) ? lim - 1 : 2);
    return pick(1, lim - 1);
  endfunction

  // A start request, the start pulse, the three response levels and the
  // two 16-bit data words, MSB first. Each bit is a low sync level followed
  // by a high level, and the high level is longer than the threshold for a
  // one. The frame is generated for the present register values. A fault
  // stretches one level past the wait limit, or random levels for
  // FaultAny. A failed response is followed by a short low level only,
  // since the reading ends right after it.
  task automatic put_reading(logic [7:0] hum, logic [7:0] temp, fault_t fault);
    logic [31:0] frame;
    logic [7:0] hum_lo;
    logic [7:0] temp_lo;
    int thr;
    int lim;
    bit rnd;
    hum_lo = 8'($urandom_range(0, 255));
    temp_lo = 8'($urandom_range(0, 255));
    frame = {hum, hum_lo, temp, temp_lo};
    thr = cfg_one_thresh;
    lim = cfg_wait_limit;
    rnd = (fault == FaultAny);
    put_tick(1'($urandom_range(0, 1)), 1'b1);
    for (int i = 1; i < cfg_start_low; i++)
      put_tick(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
    put_level(1'b1, level_len(rnd && $urandom_range(0, 9) == 0));
    put_level(1'b0, level_len(fault == FaultResponse || (rnd && $urandom_range(0, 9) == 0)));
    put_level(1'b1, level_len(rnd && $urandom_range(0, 9) == 0));
    if (fault != FaultResponse) begin
      for (int k = 31; k >= 0; k--) begin
        put_level(1'b0, level_len((fault == FaultTemperature && k == 12) ||
                                  (rnd && $urandom_range(0, 24) == 0)));
        if ((fault == FaultHumidity && k == 28) || (rnd && $urandom_range(0, 24) == 0))
          put_level(1'b1, level_len(1'b1));
        else if (frame[k])
          put_level(1'b1, pick(thr + 1, (thr + 3 < lim - 1) ? thr + 3 : lim - 1));
        else
          put_level(1'b1, pick(1, thr));
      end
    end
    put_level(1'b0, pick(1, 3));
  endtask

  // Wait until every queued tick is sent and every result has come back.
  task automatic wait_drained();
    do @(posedge clk); while (tick_q.size() != 0 || in_valid || reading_q.size() != 0);
  endtask

  // Bring the sequencer back to idle before the registers change. A
  // toggling line ends every level wait within a tick, so a reading that a
  // broken frame left running finishes quickly.
  task automatic settle();
    wait_drained();
    while (seq_ph != SeqIdle) begin
      for (int i = 0; i < 16; i++) put_tick(i[0], 1'b0);
      wait_drained();
    end
  endtask

  // APB read of one register, compared with the full expected word.
  task automatic reg_check(logic [1:0] idx, logic [DataW-1:0] want);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      report($sformatf("register %0d read %h, expected %h", idx, prdata, want));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // APB write, then a read-back of the same register unless the slot decodes
  // to no register. The write lands at the rising edge of the access cycle.
  task automatic reg_write(logic [1:0] idx, logic [DataW-1:0] val);
    logic [DataW-1:0] mask;
    mask = '0;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_START_LOW: begin
        cfg_start_low = val[StartLowW-1:0];
        mask = 32'h0000_FFFF;
      end
      REG_WAIT_LIMIT: begin
        cfg_wait_limit = val[LimitW-1:0];
        mask = 32'h0000_00FF;
      end
      REG_ONE_THRESH: begin
        cfg_one_thresh = val[LimitW-1:0];
        mask = 32'h0000_00FF;
      end
      default: ;
    endcase
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    if (mask != '0) begin
      @(negedge clk);
      penable = 1'b1;
      do @(posedge clk); while (!pready);
      if ((prdata & mask) !== (val & mask))
        report($sformatf("register %0d read back %h, expected %h",
                         idx, prdata & mask, val & mask));
      @(negedge clk);
    end
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_regs(int start_low, int limit, int thresh);
    reg_write(REG_START_LOW, start_low);
    reg_write(REG_WAIT_LIMIT, limit);
    reg_write(REG_ONE_THRESH, thresh);
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    send_idle = 1'b1;
    recv_idle = 1'b1;

    // The registers read back their reset values, and idle ticks without a
    // start request leave the sequencer idle. A full reading at the reset
    // values would need a 20000-tick start pulse.
    reg_check(REG_START_LOW, DataW'(START_LOW_RST));
    reg_check(REG_WAIT_LIMIT, DataW'(WAIT_LIMIT_RST));
    reg_check(REG_ONE_THRESH, DataW'(ONE_THRESH_RST));
    put_noise(8, 1'b0);
    settle();

    // Directed frames with short timings. They cover the value extremes and
    // a timeout in the response and in the temperature part. A write to the
    // unused register slot must leave the registers as they are.
    set_regs(2, 4, 1);
    reg_write(RegSpare, $urandom);
    put_reading(8'hFF, 8'h80, FaultNone);
    put_reading(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), FaultResponse);
    put_reading(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), FaultTemperature);
    settle();

    // Register extremes on a noisy line. A zero start length behaves as
    // one, and a zero wait limit times out on the first tick at the waited
    // level. A threshold at the top never decodes a one.
    set_regs(0, 0, 1);
    put_tick(1'b0, 1'b1);
    put_noise(12, 1'b1);
    settle();
    set_regs(1, 2, 255);
    put_tick(1'b0, 1'b1);
    put_noise(30, 1'b1);
    settle();

    // The final stretch runs at full rate with no idling on either side.
    send_idle = 1'b0;
    recv_idle = 1'b0;
    set_regs(3, 4, 1);
    put_reading(8'h00, 8'h7F, FaultHumidity);
    settle();

    repeat (20) @(posedge clk);
    if (err_cnt == 0 && reading_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
